// ----- design/ldp_pkg.sv -----
// Package for the streaming quantile estimator: payload structs, FSM states,
// command and status structs and register indexes. No dependencies.
package ldp_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DIV_BITS       = 56;

  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_MODE   = 2'd1;
  localparam logic [1:0] REG_KEEP   = 2'd2;
  localparam logic [1:0] REG_HALF   = 2'd3;

  typedef struct packed {
    logic [16:0] norm_sample;
    logic [15:0] random_u;
  } in_word_t;

  typedef struct packed {
    logic signed [19:0] perturbed_value;
    logic signed [23:0] quantile_estimate;
    logic signed [23:0] step_size;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RAND, ST_RDIV, ST_RFIN, ST_STAT, ST_DIV1, ST_DIV2,
    ST_UPD, ST_OUT
  } ldp_state_t;

  typedef struct packed {
    logic load_in;
    logic rand_prep;
    logic rand_div;
    logic rand_fin;
    logic stat;
    logic div1;
    logic div2;
    logic upd;
    logic out_load;
  } ldp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic rand_need_div;
    logic first_item;
    logic mode;
  } ldp_sts_t;

endpackage

// ----- design/ldp_div.sv -----
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on ldp_pkg.
module ldp_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [ldp_pkg::DIV_BITS-1:0] dividend,
  input  logic [ldp_pkg::DIV_BITS-1:0] divisor,
  output logic done,
  output logic [ldp_pkg::DIV_BITS-1:0] quotient
);
  import ldp_pkg::*;
  localparam int CW = $clog2(DIV_BITS + 1);

  logic [DIV_BITS-1:0] rem, den;
  logic [CW-1:0] cnt;
  logic busy;
  logic [DIV_BITS:0] trial;

  assign trial = {rem[DIV_BITS-1:0], quotient[DIV_BITS-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(DIV_BITS);
        rem <= '0;
        quotient <= dividend;
        den <= divisor;
      end else if (busy) begin
        if (!trial[DIV_BITS]) begin
          rem <= trial[DIV_BITS-1:0];
          quotient <= {quotient[DIV_BITS-2:0], 1'b1};
        end else begin
          rem <= {rem[DIV_BITS-2:0], quotient[DIV_BITS-1]};
          quotient <= {quotient[DIV_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- design/ldp_ctrl.sv -----
// Controller state machine for the estimator, sequencing the datapath.
// Depends on ldp_pkg.
module ldp_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  ldp_pkg::ldp_sts_t sts,
  output ldp_pkg::ldp_cmd_t cmd
);
  import ldp_pkg::*;

  ldp_state_t state, state_next;
  logic ovalid;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_RAND;
      ST_RAND: state_next = sts.rand_need_div ? ST_RDIV : ST_RFIN;
      ST_RDIV: if (sts.div_done) state_next = ST_RFIN;
      ST_RFIN: state_next = sts.first_item ? ST_UPD : ST_STAT;
      ST_STAT: state_next = ST_DIV1;
      ST_DIV1: if (sts.div_done) state_next = sts.mode ? ST_DIV2 : ST_UPD;
      ST_DIV2: if (sts.div_done) state_next = ST_UPD;
      ST_UPD:  state_next = ST_OUT;
      ST_OUT:  if (!ovalid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: cmd.load_in = in_valid;
      ST_RAND: begin
        cmd.rand_prep = 1'b1;
        cmd.rand_div = sts.rand_need_div;
      end
      ST_RFIN: cmd.rand_fin = 1'b1;
      ST_STAT: cmd.stat = 1'b1;
      ST_DIV1: cmd.div1 = sts.div_done;
      ST_DIV2: cmd.div2 = sts.div_done;
      ST_UPD:  cmd.upd = 1'b1;
      ST_OUT:  cmd.out_load = !ovalid || !out_stall;
      default: cmd = '0;
    endcase
  end

  assign in_stall = (state != ST_IDLE);
  assign out_valid = ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) ovalid <= 1'b1;
      else if (!out_stall) ovalid <= 1'b0;
    end
  end
endmodule

// ----- design/ldp_dpath.sv -----
// Datapath: randomizer, running statistics, step and estimate update.
// Depends on ldp_pkg and ldp_div.
module ldp_dpath #(
  parameter int COUNT_BITS = ldp_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = ldp_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  ldp_pkg::in_word_t in_word,
  input  logic [15:0] target_q,
  input  logic mode,
  input  logic [15:0] keep_q,
  input  logic [15:0] half_l,
  input  ldp_pkg::ldp_cmd_t cmd,
  output ldp_pkg::ldp_sts_t sts,
  output ldp_pkg::out_word_t out_word
);
  import ldp_pkg::*;
  localparam int W = DIV_BITS;
  localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [COUNT_BITS+15:0] FMASK = (COUNT_BITS+16)'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [W-1:0] SMAX = (W'(1) <<< 51) - 1;
  localparam logic signed [W-1:0] SMIN = -(W'(1) <<< 51);
  localparam logic signed [W-1:0] EMAX = W'(8388607);
  localparam logic signed [W-1:0] EMIN = -W'(8388608);
  localparam logic signed [W-1:0] PMAX = W'(524287);
  localparam logic signed [W-1:0] PMIN = -W'(524288);

  logic signed [W-1:0] v, u, uu, vq, tt, radd, num, lam;
  logic signed [W-1:0] rmin, rmax, rsum, est, sum_n, min_n, max_n;
  logic [COUNT_BITS-1:0] cnt, lowc, highc, cnt_b;
  logic [COUNT_BITS+15:0] thr;
  logic [COUNT_BITS-1:0] tfl, tce;
  logic rneg, div_start, div_done, sneg, first, sts_div_used;
  logic [W-1:0] dv_n, dv_d, rdv_n, rdv_d, quot;
  logic signed [W-1:0] qs;

  ldp_div u_div (.clk(clk), .rst(rst), .start(div_start), .dividend(dv_n),
                 .divisor(dv_d), .done(div_done), .quotient(quot));

  function automatic logic signed [W-1:0] clampw(logic signed [W-1:0] x,
      logic signed [W-1:0] lo, logic signed [W-1:0] hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  assign qs = $signed(quot);
  assign cnt_b = (cnt == CMAX) ? CMAX : cnt + 1'b1;

  // randomizer region selection and its divide operands
  always_comb begin
    logic signed [W-1:0] q, d;
    logic [FRAC_BITS+17:0] p;
    q = W'(keep_q);
    d = (uu - vq) >>> FRAC_BITS;
    // In the middle region d is below ONE, so a narrow product suffices.
    p = {half_l, 1'b0} * d[FRAC_BITS:0];
    if (uu < vq) begin
      rdv_n = uu; rdv_d = q;
    end else if (uu < tt) begin
      rdv_n = W'(p); rdv_d = ONE - q;
    end else begin
      rdv_n = uu - tt; rdv_d = q;
    end
  end

  // statistics updated with the new sample, fed straight to the step divide
  assign min_n = (num < rmin) ? num : rmin;
  assign max_n = (num > rmax) ? num : rmax;
  assign sum_n = clampw(rsum + num, SMIN, SMAX);

  always_comb begin
    dv_n = rdv_n;
    dv_d = rdv_d;
    if (cmd.stat) begin
      if (mode) begin
        dv_n = sum_n[W-1] ? -sum_n : sum_n;
        dv_d = W'(cnt);
      end else begin
        dv_n = max_n - min_n;
        dv_d = W'(cnt);
      end
    end
    if (cmd.div1) begin
      dv_n = quot;
      dv_d = W'(cnt) - 1;
    end
  end

  assign sts.rand_need_div = !(!(uu < tt) && u > ONE) &&
                             $signed(rdv_d) > 0;
  assign div_start = cmd.rand_div || cmd.stat || (cmd.div1 && mode);
  assign sts.div_done = div_done;
  assign sts.first_item = first;
  assign sts.mode = mode;
  assign thr = cnt * target_q;
  assign tfl = COUNT_BITS'(thr >> FRAC_BITS);
  assign tce = tfl + COUNT_BITS'(|(thr & FMASK));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; lowc <= '0; highc <= '0;
      rsum <= '0; rmin <= PMAX; rmax <= '0; est <= '0;
    end else begin
      if (cmd.load_in) begin
        v  <= W'(in_word.norm_sample);
        u  <= W'(in_word.random_u);
        uu <= W'(in_word.random_u) <<< FRAC_BITS;
        vq <= W'(in_word.norm_sample) * W'(keep_q);
        tt <= ONE * ONE + W'(in_word.norm_sample) * W'(keep_q) - W'(keep_q) * ONE;
      end
      if (cmd.rand_prep) begin
        radd <= '0;
        rneg <= 1'b0;
        if (uu < vq) radd <= -W'(half_l);
        else if (uu < tt) radd <= v - W'(half_l);
        else if (u <= ONE) radd <= v + W'(half_l);
        else rneg <= 1'b1;
        first <= (cnt_b <= 1);
        cnt <= cnt_b;
      end
      // quotient taken as zero when the divisor is not positive
      if (cmd.rand_fin) begin
        num <= rneg ? '0 :
               clampw((sts_div_used ? qs : '0) + radd, PMIN, PMAX);
      end
      if (cmd.stat) begin
        rmin <= min_n;
        rmax <= max_n;
        rsum <= sum_n;
      end
      if (cmd.div1 && !mode) lam <= clampw(qs, EMIN, EMAX);
      if (cmd.div2) lam <= clampw((sneg ? -qs : qs) * 2, EMIN, EMAX);
      if (cmd.upd) begin
        if (first) begin
          est <= num; lam <= '0;
        end else if (!(num > est)) begin
          if (W'(lowc) + 1 > W'(tfl)) begin
            est <= clampw(est - lam, EMIN, EMAX);
            highc <= (highc == CMAX) ? CMAX : highc + 1'b1;
          end else lowc <= (lowc == CMAX) ? CMAX : lowc + 1'b1;
        end else begin
          if (W'(highc) + 1 + W'(tce) > W'(cnt)) begin
            est <= clampw(est + lam, EMIN, EMAX);
            lowc <= (lowc == CMAX) ? CMAX : lowc + 1'b1;
          end else highc <= (highc == CMAX) ? CMAX : highc + 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_word.perturbed_value   <= num[19:0];
        out_word.quantile_estimate <= est[23:0];
        out_word.step_size         <= lam[23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sts_div_used <= 1'b0;
    else if (cmd.rand_prep) sts_div_used <= sts.rand_need_div;
  end

  always_ff @(posedge clk) begin
    if (cmd.rand_fin) sneg <= 1'b0;
    if (cmd.stat) sneg <= sum_n[W-1];
  end
endmodule

// ----- design/ldp_streaming_quantile_estimator.sv -----
// Top level of the streaming quantile estimator: register file, controller
// and datapath. Depends on ldp_pkg, ldp_ctrl, ldp_dpath and ldp_div.
//
//  channel   direction   handshake       word
//  in        into block  valid / stall   ldp_pkg::in_word_t
//  out       from block  valid / stall   ldp_pkg::out_word_t
//  cfg       into block  valid / ready   register index and data
//
// Without output stalls the time an item takes is set by the 56-step shared
// restoring divider: at most one division for the randomizer quotient, and one
// in step mode zero or two in mode one for the step. The first item after
// reset needs no step division. Reset is synchronous, resets all statistics
// and loads register defaults. A stall on the output holds the result word; a
// new result waits in the output state until the previous one has gone, and
// the next input word is taken once the new result is loaded.
module ldp_streaming_quantile_estimator #(
  parameter int COUNT_BITS = ldp_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = ldp_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  ldp_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output ldp_pkg::out_word_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import ldp_pkg::*;

  logic [15:0] target_q, keep_q, half_l;
  logic mode;
  ldp_cmd_t cmd;
  ldp_sts_t sts;

  assign cfg_ready = 1'b1;

  // Register file; all four indexes are in use.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_q <= 16'd64881;
      mode <= 1'b0;
      keep_q <= 16'd22510;
      half_l <= 16'd8476;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET: target_q <= cfg_data;
        REG_MODE:   mode <= cfg_data[0];
        REG_KEEP:   keep_q <= cfg_data;
        REG_HALF:   half_l <= cfg_data;
        default: ;
      endcase
    end
  end

  ldp_ctrl u_ctrl (.clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
                   .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd));

  ldp_dpath #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk(clk), .rst(rst), .in_word(in_data), .target_q(target_q), .mode(mode),
    .keep_q(keep_q), .half_l(half_l), .cmd(cmd), .sts(sts), .out_word(out_data));
endmodule
